/* design/battery_protection_controller_macros.svh */
// assertion helpers shared by the battery protection controller
`ifndef BATTERY_PROTECTION_CONTROLLER_MACROS_SVH
`define BATTERY_PROTECTION_CONTROLLER_MACROS_SVH

// checked only while out of reset
`define BPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// checked on every edge, reset included
`define BPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* design/bpc_pkg.sv */
`default_nettype none

package bpc_pkg;

    localparam int unsigned TICK_MS       = 200;
    localparam int unsigned MS_PER_SECOND = 1000;
    // ticks * TICK_MS and seconds * MS_PER_SECOND both fit here
    localparam int unsigned ELAPSED_W     = 26;

    localparam int unsigned ALERT_W = 9;
    localparam int unsigned A_OV  = 0;
    localparam int unsigned A_UV  = 1;
    localparam int unsigned A_OCC = 2;
    localparam int unsigned A_OCD = 3;
    localparam int unsigned A_SCD = 4;
    localparam int unsigned A_OTC = 5;
    localparam int unsigned A_LTC = 6;
    localparam int unsigned A_OTD = 7;
    localparam int unsigned A_LTD = 8;

    localparam int unsigned S_TDATA_W = 88;
    localparam int unsigned S_TUSER_W = 3;
    localparam int unsigned M_TDATA_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_OCD  = 3'd1,
        OP_SCD  = 3'd2,
        OP_OV   = 3'd3,
        OP_UV   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_CHARGE    = 2'd0,
        MODE_DISCHARGE = 2'd1,
        MODE_STANDBY   = 2'd2,
        MODE_SLEEP     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        RES_NONE    = 2'd0,
        RES_UNLOCK  = 2'd1,
        RES_RELEASE = 2'd2
    } resume_t;

    typedef enum logic [2:0] {
        REG_CHG_CUR_LIMIT  = 3'd0,
        REG_CHG_TEMP       = 3'd1,
        REG_DIS_TEMP       = 3'd2,
        REG_OV_REL_MV      = 3'd3,
        REG_UV_REL_MV      = 3'd4,
        REG_OCC_TRIP_SEC   = 3'd5,
        REG_OCC_REL_SEC    = 3'd6,
        REG_OCD_SCD_REL    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic        [15:0] cell_v_min;
        logic        [15:0] cell_v_max;
        logic signed [15:0] temp_low;
        logic signed [15:0] temp_high;
        logic               temp_valid;
        logic signed [15:0] pack_current;
        logic        [1:0]  pack_mode;
        logic        [2:0]  operation;
    } item_t;

    typedef struct packed {
        logic [1:0]         discharge_resume;
        logic [1:0]         charge_resume;
        logic               discharge_lock;
        logic               charge_lock;
        logic [ALERT_W-1:0] alert_mask;
    } result_t;

    typedef struct packed {
        logic [ALERT_W-1:0] alert_bits;
        logic [15:0]        occ_ticks;
        logic [15:0]        charge_release_ticks;
        logic [15:0]        discharge_release_ticks;
    } state_t;

    typedef struct packed {
        logic signed [15:0] charge_current_limit;
        logic [63:0]        charge_temp_limits;
        logic [63:0]        discharge_temp_limits;
        logic [15:0]        overvolt_release_mv;
        logic [15:0]        undervolt_release_mv;
        logic [7:0]         occ_trip_seconds;
        logic [7:0]         occ_release_seconds;
        logic [15:0]        ocd_scd_release_seconds;
    } cfg_t;

    // saturating tick counter step
    function automatic logic [15:0] bump(input logic [15:0] t);
        return (t != 16'hFFFF) ? t + 16'd1 : t;
    endfunction

    // floor(ticks * TICK_MS / 1000) >= secs  <=>  ticks * TICK_MS >= secs * 1000
    function automatic logic elapsed(input logic [15:0] ticks, input logic [7:0] secs);
        logic [ELAPSED_W-1:0] lhs;
        logic [ELAPSED_W-1:0] rhs;
        lhs = ELAPSED_W'(ticks) * ELAPSED_W'(TICK_MS);
        rhs = ELAPSED_W'(secs) * ELAPSED_W'(MS_PER_SECOND);
        return lhs >= rhs;
    endfunction

endpackage

`default_nettype wire

/* design/battery_protection_controller.sv */
// Battery pack protection controller. Each input beat is a protection tick
// (operation 0) or a hardware alert event (1 OCD, 2 SCD, 3 OV, 4 UV) and
// gives exactly one result beat: the nine-bit alert mask after the beat,
// charge/discharge lock pulses and resume codes. The block takes one beat
// per clock while results are taken. An accepted beat sits in the input
// register while a single pass of compare and counter logic runs, and its
// result beat is valid once the beat moves on into the result register,
// with the alert mask and the tick counters updated as it does so. A
// result that is not taken holds the input register, and the input then
// stalls once that register is full. Operation codes 5 to 7
// return the current mask with no other effect. Configuration writes go
// straight into the registers and must only happen while no beat is in
// flight.
`default_nettype none

`include "battery_protection_controller_macros.svh"

module battery_protection_controller (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pack_mode, pack_current, temp_valid, temp_high, temp_low, cell_v_max,
    // cell_v_min, zero fill
    input  wire logic [bpc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // operation
    input  wire logic [bpc_pkg::S_TUSER_W-1:0]    s_axis_tuser,

    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // alert_mask, charge_lock, discharge_lock, charge_resume,
    // discharge_resume, zero fill
    output logic [bpc_pkg::M_TDATA_W-1:0]         m_axis_tdata,

    input  wire logic                             cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import bpc_pkg::*;

    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    logic    out_valid_reg;
    state_t  st_reg;
    state_t  st_next;
    result_t res_next;
    cfg_t    cfg_reg;
    logic    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    bpc_core u_core (
        .item    (item_reg),
        .st      (st_reg),
        .cfg     (cfg_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg.operation    <= s_axis_tuser;
            item_reg.pack_mode    <= s_axis_tdata[1:0];
            item_reg.pack_current <= $signed(s_axis_tdata[17:2]);
            item_reg.temp_valid   <= s_axis_tdata[18];
            item_reg.temp_high    <= $signed(s_axis_tdata[34:19]);
            item_reg.temp_low     <= $signed(s_axis_tdata[50:35]);
            item_reg.cell_v_max   <= s_axis_tdata[66:51];
            item_reg.cell_v_min   <= s_axis_tdata[82:67];
        end
    end

    // result register and protection state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.charge_current_limit    <= 16'sd32767;
            cfg_reg.charge_temp_limits      <= '0;
            cfg_reg.discharge_temp_limits   <= '0;
            cfg_reg.overvolt_release_mv     <= 16'd4150;
            cfg_reg.undervolt_release_mv    <= 16'd3000;
            cfg_reg.occ_trip_seconds        <= 8'd2;
            cfg_reg.occ_release_seconds     <= 8'd30;
            cfg_reg.ocd_scd_release_seconds <= 16'd7710;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CHG_CUR_LIMIT: cfg_reg.charge_current_limit <= $signed(cfg_wdata[15:0]);
                REG_CHG_TEMP:      cfg_reg.charge_temp_limits      <= cfg_wdata;
                REG_DIS_TEMP:      cfg_reg.discharge_temp_limits   <= cfg_wdata;
                REG_OV_REL_MV:     cfg_reg.overvolt_release_mv     <= cfg_wdata[15:0];
                REG_UV_REL_MV:     cfg_reg.undervolt_release_mv    <= cfg_wdata[15:0];
                REG_OCC_TRIP_SEC:  cfg_reg.occ_trip_seconds        <= cfg_wdata[7:0];
                REG_OCC_REL_SEC:   cfg_reg.occ_release_seconds     <= cfg_wdata[7:0];
                REG_OCD_SCD_REL:   cfg_reg.ocd_scd_release_seconds <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, res_reg};

    `BPC_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> !out_valid_reg,
        "result valid right after reset")
    `BPC_ASSERT(a_ov_unlock_clears,
        out_valid_reg && (res_reg.charge_resume == RES_UNLOCK) |-> !res_reg.alert_mask[A_OV],
        "ov unlock beat still shows ov")
    `BPC_ASSERT(a_uv_unlock_clears,
        out_valid_reg && (res_reg.discharge_resume == RES_UNLOCK) |-> !res_reg.alert_mask[A_UV],
        "uv unlock beat still shows uv")
    `BPC_ASSERT(a_crel_needs_occ,
        (st_reg.charge_release_ticks != '0) |-> st_reg.alert_bits[A_OCC],
        "charge release counter running without occ")
    `BPC_ASSERT(a_drel_needs_ocd_scd,
        (st_reg.discharge_release_ticks != '0)
            |-> (st_reg.alert_bits[A_OCD] || st_reg.alert_bits[A_SCD]),
        "discharge release counter running without ocd or scd")

endmodule

`default_nettype wire

/* design/bpc_core.sv */
`default_nettype none

module bpc_core (
    input  bpc_pkg::item_t   item,
    input  bpc_pkg::state_t  st,
    input  bpc_pkg::cfg_t    cfg,
    output bpc_pkg::state_t  st_next,
    output bpc_pkg::result_t res
);
    import bpc_pkg::*;

    logic signed [15:0] chg_ot_trip, chg_ot_rel, chg_lt_trip, chg_lt_rel;
    logic signed [15:0] dis_ot_trip, dis_ot_rel, dis_lt_trip, dis_lt_rel;
    logic [15:0]        occ_inc, crel_inc, drel_inc;
    logic               occ_trip_hit, occ_rel_hit, ocd_rel_hit, scd_rel_hit;

    logic [ALERT_W-1:0] alert;
    logic [15:0]        occ, crel, drel;
    logic               clk_lock, dis_lock;
    logic [1:0]         cres, dres;

    assign chg_ot_trip = $signed(cfg.charge_temp_limits[15:0]);
    assign chg_ot_rel  = $signed(cfg.charge_temp_limits[31:16]);
    assign chg_lt_trip = $signed(cfg.charge_temp_limits[47:32]);
    assign chg_lt_rel  = $signed(cfg.charge_temp_limits[63:48]);
    assign dis_ot_trip = $signed(cfg.discharge_temp_limits[15:0]);
    assign dis_ot_rel  = $signed(cfg.discharge_temp_limits[31:16]);
    assign dis_lt_trip = $signed(cfg.discharge_temp_limits[47:32]);
    assign dis_lt_rel  = $signed(cfg.discharge_temp_limits[63:48]);

    assign occ_inc  = bump(st.occ_ticks);
    assign crel_inc = bump(st.charge_release_ticks);
    assign drel_inc = bump(st.discharge_release_ticks);

    assign occ_trip_hit = elapsed(occ_inc, cfg.occ_trip_seconds);
    assign occ_rel_hit  = elapsed(crel_inc, cfg.occ_release_seconds);
    assign ocd_rel_hit  = elapsed(drel_inc, cfg.ocd_scd_release_seconds[7:0]);
    assign scd_rel_hit  = elapsed(drel_inc, cfg.ocd_scd_release_seconds[15:8]);

    always_comb begin
        alert    = st.alert_bits;
        occ      = st.occ_ticks;
        crel     = st.charge_release_ticks;
        drel     = st.discharge_release_ticks;
        clk_lock = 1'b0;
        dis_lock = 1'b0;
        cres     = RES_NONE;
        dres     = RES_NONE;

        case (item.operation)
            OP_TICK: begin
                case (item.pack_mode)
                    MODE_CHARGE: begin
                        if (item.pack_current > cfg.charge_current_limit) begin
                            occ = occ_inc;
                            if (occ_trip_hit) begin
                                clk_lock   = 1'b1;
                                alert[A_OCC] = 1'b1;
                            end
                        end else if (!item.temp_valid) begin
                            // no usable temperature, counter kept
                        end else if (item.temp_high > chg_ot_trip) begin
                            clk_lock     = 1'b1;
                            alert[A_OTC] = 1'b1;
                        end else if (item.temp_low < chg_lt_trip) begin
                            clk_lock     = 1'b1;
                            alert[A_LTC] = 1'b1;
                        end else begin
                            occ = '0;
                        end
                    end
                    MODE_DISCHARGE: begin
                        if (item.temp_valid) begin
                            if (item.temp_high > dis_ot_trip) begin
                                dis_lock     = 1'b1;
                                alert[A_OTD] = 1'b1;
                            end else if (item.temp_low < dis_lt_trip) begin
                                dis_lock     = 1'b1;
                                alert[A_LTD] = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase

                if (alert != '0) begin
                    // charge side, highest priority first
                    if (alert[A_OV]) begin
                        if (item.cell_v_max < cfg.overvolt_release_mv) begin
                            alert[A_OV] = 1'b0;
                            cres        = RES_UNLOCK;
                        end
                    end else if (alert[A_OTC]) begin
                        if (item.temp_valid && item.temp_high < chg_ot_rel) begin
                            alert[A_OTC] = 1'b0;
                            cres         = RES_RELEASE;
                        end
                    end else if (alert[A_LTC]) begin
                        if (item.temp_valid && item.temp_low > chg_lt_rel) begin
                            alert[A_LTC] = 1'b0;
                            cres         = RES_RELEASE;
                        end
                    end else if (alert[A_OCC]) begin
                        crel = crel_inc;
                        if (occ_rel_hit) begin
                            crel         = '0;
                            alert[A_OCC] = 1'b0;
                            cres         = RES_RELEASE;
                        end
                    end

                    // discharge side, ocd and scd share one counter
                    if (alert[A_UV]) begin
                        if (item.cell_v_min > cfg.undervolt_release_mv) begin
                            alert[A_UV] = 1'b0;
                            dres        = RES_UNLOCK;
                        end
                    end else if (alert[A_OTD]) begin
                        if (item.temp_valid && item.temp_high < dis_ot_rel) begin
                            alert[A_OTD] = 1'b0;
                            dres         = RES_RELEASE;
                        end
                    end else if (alert[A_LTD]) begin
                        if (item.temp_valid && item.temp_low > dis_lt_rel) begin
                            alert[A_LTD] = 1'b0;
                            dres         = RES_RELEASE;
                        end
                    end else if (alert[A_OCD]) begin
                        drel = drel_inc;
                        if (ocd_rel_hit) begin
                            drel         = '0;
                            alert[A_OCD] = 1'b0;
                            dres         = RES_RELEASE;
                        end
                    end else if (alert[A_SCD]) begin
                        drel = drel_inc;
                        if (scd_rel_hit) begin
                            drel         = '0;
                            alert[A_SCD] = 1'b0;
                            dres         = RES_RELEASE;
                        end
                    end
                end
            end
            OP_OCD: begin
                if (!alert[A_OCD]) begin
                    dis_lock     = 1'b1;
                    alert[A_OCD] = 1'b1;
                end
            end
            OP_SCD: begin
                if (!alert[A_SCD]) begin
                    dis_lock     = 1'b1;
                    alert[A_SCD] = 1'b1;
                end
            end
            OP_OV: begin
                if (!alert[A_OV]) begin
                    clk_lock    = 1'b1;
                    alert[A_OV] = 1'b1;
                end
            end
            OP_UV: begin
                if (!alert[A_UV]) begin
                    dis_lock    = 1'b1;
                    alert[A_UV] = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign st_next.alert_bits              = alert;
    assign st_next.occ_ticks               = occ;
    assign st_next.charge_release_ticks    = crel;
    assign st_next.discharge_release_ticks = drel;

    assign res.alert_mask       = alert;
    assign res.charge_lock      = clk_lock;
    assign res.discharge_lock   = dis_lock;
    assign res.charge_resume    = cres;
    assign res.discharge_resume = dres;

endmodule

`default_nettype wire
